### design/uet_pkg.sv
// ----------------------------------------------------------------------------
// uet_pkg
// Shared types and constants for the unread event tracker.
// ----------------------------------------------------------------------------
package uet_pkg;

  localparam int MaxEvents  = 4096;
  localparam int NumSources = 256;
  localparam int EvW  = $clog2(MaxEvents);
  localparam int SrcW = $clog2(NumSources);
  localparam int CntW = EvW + 1;

  typedef enum logic [1:0] {
    ACT_POST  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SWEEP = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  source;
    logic [12:0] count;
  } req_t;

  typedef struct packed {
    logic [12:0] unread;
    logic        dropped;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

### design/uet_mark_ram.sv
// ----------------------------------------------------------------------------
// uet_mark_ram
// Read-bit and next-link store, one entry per event, registered read.
// Read bits are valid only below the clear pointer after reset.
// ----------------------------------------------------------------------------
module uet_mark_ram (
  input  logic                   clk,
  input  logic [uet_pkg::EvW-1:0] raddr,
  output logic                   rmark,
  output logic [uet_pkg::EvW-1:0] rlink,
  input  logic                   mwe,
  input  logic [uet_pkg::EvW-1:0] maddr,
  input  logic                   mdata,
  input  logic                   lwe,
  input  logic [uet_pkg::EvW-1:0] laddr,
  input  logic [uet_pkg::EvW-1:0] ldata
);
  logic                    mark_mem [uet_pkg::MaxEvents];
  logic [uet_pkg::EvW-1:0] link_mem [uet_pkg::MaxEvents];

  always_ff @(posedge clk) begin
    if (mwe) mark_mem[maddr] <= mdata;
    rmark <= mark_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (lwe) link_mem[laddr] <= ldata;
    rlink <= link_mem[raddr];
  end
endmodule

### design/unread_event_tracker_unit.sv
// ----------------------------------------------------------------------------
// unread_event_tracker_unit
// Per-source event lists with read marks; answers unread count per request.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// req     | in  | start & !busy          | req   (uet_pkg::req_t)
// rsp     | out | done strobe, one cycle | rsp   (uet_pkg::rsp_t)
//
// Post and unused code: the request passes through LOOK and then DONE.
// Clear: LOOK, then WALK visits each listed event with a read phase and a
// mark phase, then DONE. Sweep: the same through SWEEP for each newly swept
// event; each event is marked once, with one read and one write of the mark
// memory per step. After reset a clearing pass zeroes all 4096 read bits;
// busy is high meanwhile. The receiver cannot stall.
module unread_event_tracker_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  uet_pkg::req_t  req,
  output logic           busy,
  output logic           done,
  output uet_pkg::rsp_t  rsp
);
  localparam int EvW  = uet_pkg::EvW;
  localparam int CntW = uet_pkg::CntW;

  uet_pkg::state_t state, state_next;

  logic [EvW-1:0] head_mem [uet_pkg::NumSources];
  logic [EvW-1:0] tail_mem [uet_pkg::NumSources];
  logic [uet_pkg::NumSources-1:0] nonempty;

  logic [CntW-1:0] posted, read_cnt, swept, limit;
  logic [CntW-1:0] init_ptr;
  logic            initing;
  uet_pkg::req_t   cur;
  logic [EvW-1:0]  idx, tail_r, head_r;
  logic            dropped;
  logic            step_ph; // 0: read issued, 1: data back

  logic            rmark;
  logic [EvW-1:0]  rlink;
  logic [EvW-1:0]  raddr;
  logic            mwe, lwe;
  logic [EvW-1:0]  maddr, laddr, ldata;
  logic            mdata;

  logic [7:0] src;
  logic       src_ok, full;
  assign src    = cur.source;
  assign src_ok = ({1'b0, src} < 9'(uet_pkg::NumSources));
  assign full   = (posted == CntW'(uet_pkg::MaxEvents));

  uet_mark_ram u_ram (
    .clk(clk), .raddr(raddr), .rmark(rmark), .rlink(rlink),
    .mwe(mwe), .maddr(maddr), .mdata(mdata),
    .lwe(lwe), .laddr(laddr), .ldata(ldata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      uet_pkg::ST_IDLE:  if (start && !busy) state_next = uet_pkg::ST_LOOK;
      uet_pkg::ST_LOOK: begin
        state_next = uet_pkg::ST_DONE;
        case (uet_pkg::action_t'(cur.action))
          uet_pkg::ACT_CLEAR:
            if (src_ok && nonempty[src[uet_pkg::SrcW-1:0]])
              state_next = uet_pkg::ST_WALK;
          uet_pkg::ACT_SWEEP:
            if (limit > swept) state_next = uet_pkg::ST_SWEEP;
          default: state_next = uet_pkg::ST_DONE;
        endcase
      end
      uet_pkg::ST_WALK:  if (step_ph && idx == tail_r) state_next = uet_pkg::ST_DONE;
      uet_pkg::ST_SWEEP: if (step_ph && CntW'(idx) + 1'b1 == limit)
                           state_next = uet_pkg::ST_DONE;
      uet_pkg::ST_DONE:  state_next = uet_pkg::ST_IDLE;
      default:           state_next = uet_pkg::ST_IDLE;
    endcase
  end

  // memory control and outputs
  always_comb begin
    raddr = idx;
    mwe   = 1'b0;
    maddr = idx;
    mdata = 1'b1;
    lwe   = 1'b0;
    laddr = tail_r;
    ldata = posted[EvW-1:0];
    busy  = initing || (state != uet_pkg::ST_IDLE);
    done  = (state == uet_pkg::ST_DONE);
    rsp.unread  = 13'(posted - read_cnt);
    rsp.dropped = dropped;
    if (initing) begin
      mwe   = 1'b1;
      maddr = init_ptr[EvW-1:0];
      mdata = 1'b0;
    end
    case (state)
      uet_pkg::ST_LOOK:
        if (uet_pkg::action_t'(cur.action) == uet_pkg::ACT_POST && src_ok && !full &&
            nonempty[src[uet_pkg::SrcW-1:0]])
          lwe = 1'b1;
      uet_pkg::ST_WALK, uet_pkg::ST_SWEEP:
        if (step_ph) mwe = 1'b1;
      default: ;
    endcase
  end

  // head and tail of the requested source, read at the accepting edge
  always_ff @(posedge clk) begin
    if (state == uet_pkg::ST_IDLE && start && !busy) begin
      head_r <= head_mem[req.source];
      tail_r <= tail_mem[req.source];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= uet_pkg::ST_IDLE;
      nonempty <= '0;
      posted   <= '0;
      read_cnt <= '0;
      swept    <= '0;
      init_ptr <= '0;
      initing  <= 1'b1;
      step_ph  <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      state <= state_next;
      if (initing) begin
        init_ptr <= init_ptr + 1'b1;
        if (init_ptr == CntW'(uet_pkg::MaxEvents - 1)) initing <= 1'b0;
      end
      case (state)
        uet_pkg::ST_IDLE: if (start && !busy) begin
          cur     <= req;
          dropped <= 1'b0;
          step_ph <= 1'b0;
        end
        uet_pkg::ST_LOOK: begin
          case (uet_pkg::action_t'(cur.action))
            uet_pkg::ACT_POST: if (src_ok) begin
              if (full) dropped <= 1'b1;
              else begin
                posted <= posted + 1'b1;
                tail_mem[src[uet_pkg::SrcW-1:0]] <= posted[EvW-1:0];
                if (!nonempty[src[uet_pkg::SrcW-1:0]]) begin
                  head_mem[src[uet_pkg::SrcW-1:0]] <= posted[EvW-1:0];
                  nonempty[src[uet_pkg::SrcW-1:0]] <= 1'b1;
                end
              end
            end
            uet_pkg::ACT_CLEAR: if (src_ok) begin
              idx <= head_r;
              nonempty[src[uet_pkg::SrcW-1:0]] <= 1'b0;
            end
            uet_pkg::ACT_SWEEP: begin
              idx <= swept[EvW-1:0];
              if (limit > swept) swept <= limit;
            end
            default: ;
          endcase
        end
        uet_pkg::ST_WALK, uet_pkg::ST_SWEEP: begin
          step_ph <= !step_ph;
          if (step_ph) begin
            if (!rmark) read_cnt <= read_cnt + 1'b1;
            idx <= (state == uet_pkg::ST_WALK) ? rlink : idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // clamped sweep limit
  assign limit = (cur.count > 13'(posted)) ? posted : CntW'(cur.count);
endmodule

### design/uet_checker.sv
// ----------------------------------------------------------------------------
// uet_checker
// Port-level checks for the unread event tracker.
// ----------------------------------------------------------------------------
module uet_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input uet_pkg::rsp_t rsp
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done outside a request");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_unread_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.unread <= 13'd4096)) else $error("unread out of range");
endmodule

bind unread_event_tracker_unit uet_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
